>>> src/hbf_pkg.sv
// ----------------------------------------------------------------------------
// hbf_pkg
// Shared types, codes and helpers for the hierarchical bitmap free finder.
// ----------------------------------------------------------------------------
package hbf_pkg;

    // fixed word geometry
    localparam int unsigned WORD_BITS        = 32;
    localparam int unsigned POS_W            = 5;
    localparam int unsigned DEFAULT_MAX_BITS = 32768;
    localparam logic [WORD_BITS-1:0] ALL_ONES = '1;

    // payload widths
    localparam int unsigned REQ_W      = 3;
    localparam int unsigned IDX_W      = 15;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned LEAF_IDX_W = IDX_W - POS_W;

    // request codes
    localparam logic [REQ_W-1:0] REQ_SET       = 3'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_TEST      = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FIND      = 3'd3;
    localparam logic [REQ_W-1:0] REQ_RESET_ALL = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BITS    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_MODE = 1'd1;

    localparam logic [CFG_DATA_W-1:0] NUM_BITS_RESET = 16'd32768;

    // operand of the shared word unit
    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic [POS_W-1:0]     pos;
        logic                 val;
    } wu_req_t;

    // results of the shared word unit
    typedef struct packed {
        logic [WORD_BITS-1:0] new_word;
        logic [POS_W-1:0]     low_zero;
        logic                 all_ones;
        logic                 new_all_ones;
    } wu_rsp_t;

    // leaf word written by the initialization sweep for leaf k
    function automatic logic [WORD_BITS-1:0] sweep_word(
        input logic [LEAF_IDX_W-1:0] k,
        input logic [CFG_DATA_W-1:0] n,
        input logic                  inv
    );
        logic [CFG_DATA_W-POS_W-1:0] full_words;
        logic [WORD_BITS-1:0]        fill;
        logic [WORD_BITS-1:0]        pad_mask;
        full_words = n[CFG_DATA_W-1:POS_W];
        fill       = {WORD_BITS{inv}};
        pad_mask   = ALL_ONES << n[POS_W-1:0];
        if ({1'b0, k} < full_words)
            return fill;
        else if (({1'b0, k} == full_words) && (n[POS_W-1:0] != '0))
            return fill | pad_mask;
        else
            return ALL_ONES;
    endfunction

endpackage

>>> src/hbf_word_unit.sv
// ----------------------------------------------------------------------------
// hbf_word_unit
// Shared word unit: bit replace, all-ones detect and lowest-zero search.
// ----------------------------------------------------------------------------
module hbf_word_unit (
    input  hbf_pkg::wu_req_t req,
    output hbf_pkg::wu_rsp_t rsp
);
    import hbf_pkg::*;

    logic [WORD_BITS-1:0] pos_mask;
    logic [WORD_BITS-1:0] new_word;
    logic [POS_W-1:0]     low_zero;

    // replace one bit of the word
    assign pos_mask = WORD_BITS'(1) << req.pos;
    assign new_word = (req.word & ~pos_mask) | (req.val ? pos_mask : '0);

    // lowest zero bit, 31 when the word is all ones
    always_comb
    begin
        low_zero = POS_W'(WORD_BITS - 1);
        for (int i = WORD_BITS - 2; i >= 0; i--)
        begin
            if (!req.word[i])
                low_zero = POS_W'(i);
        end
    end

    assign rsp.new_word     = new_word;
    assign rsp.low_zero     = low_zero;
    assign rsp.all_ones     = &req.word;
    assign rsp.new_all_ones = &new_word;

endmodule

>>> src/hierarchical_bitmap_free_finder_core.sv
// ----------------------------------------------------------------------------
// hierarchical_bitmap_free_finder_core
// Three-level 32-way summary bitmap with set, clear, test, find and reset.
// ----------------------------------------------------------------------------
// One request is worked on at a time, and its result lands in an output
// register so the next request can be taken while the result waits. Set and
// clear read the leaf, write the leaf and middle word, then update the top;
// find searches top, middle and leaf in turn with the shared word unit and
// the single leaf memory read port; other codes, out-of-range indexes and a
// find on a full map go straight to the result. Reset all runs an
// initialization sweep over the leaf memory, one leaf word a cycle. Reset
// itself and a register write run the same sweep and keep the input stalled
// until it ends. Register writes are taken while idle or during a sweep that
// no reset-all request waits on, and restart the sweep; the input is stalled
// while a register write is offered.
// ----------------------------------------------------------------------------
module hierarchical_bitmap_free_finder_core #(
    parameter int unsigned MAX_BITS = hbf_pkg::DEFAULT_MAX_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [hbf_pkg::REQ_W-1:0]      req_type,
    input  logic [hbf_pkg::IDX_W-1:0]      bit_index,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [hbf_pkg::STATUS_W-1:0]   status,
    output logic [hbf_pkg::IDX_W-1:0]      found_index,
    output logic                           bit_value,
    output logic                           full_flag,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hbf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hbf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import hbf_pkg::*;

    localparam int unsigned LEAF_COUNT = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned MID_COUNT  = (LEAF_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned LEAF_AW    = $clog2(LEAF_COUNT);
    localparam int unsigned MID_AW     = (MID_COUNT > 1) ? $clog2(MID_COUNT) : 1;

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_SWEEP  = 4'd1;
    localparam logic [3:0] ST_IDLE   = 4'd2;
    localparam logic [3:0] ST_MODIFY = 4'd3;
    localparam logic [3:0] ST_TOP    = 4'd4;
    localparam logic [3:0] ST_FTOP   = 4'd5;
    localparam logic [3:0] ST_FMID   = 4'd6;
    localparam logic [3:0] ST_FLEAF  = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;

    // state and request context
    logic [3:0]            state_reg, state_next;
    logic [REQ_W-1:0]      req_reg, req_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [POS_W-1:0]      t_reg, t_next;
    logic [LEAF_IDX_W-1:0] k_reg, k_next;
    logic                  k_oob_reg, k_oob_next;
    logic [LEAF_AW-1:0]    sweep_cnt_reg, sweep_cnt_next;
    logic                  reply_reg, reply_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [IDX_W-1:0]      res_found_reg, res_found_next;
    logic                  res_value_reg, res_value_next;

    // configuration
    logic [CFG_DATA_W-1:0] num_bits_reg;
    logic                  invert_reg;
    logic [CFG_DATA_W-1:0] used_bits;

    // summary levels
    logic [WORD_BITS-1:0]  mid_reg [MID_COUNT];
    logic [WORD_BITS-1:0]  top_reg, top_next;

    // leaf memory
    logic [WORD_BITS-1:0]  leaf_mem [LEAF_COUNT];
    logic [WORD_BITS-1:0]  leaf_rdata_reg;
    logic [LEAF_AW-1:0]    leaf_rd_addr;
    logic                  leaf_we;
    logic [LEAF_AW-1:0]    leaf_wr_addr;
    logic [WORD_BITS-1:0]  leaf_wr_data;

    // middle level write control
    logic                  mid_fill;
    logic                  mid_we;
    logic [POS_W-1:0]      mid_wr_idx;
    logic [POS_W-1:0]      mid_wr_bit;
    logic                  mid_wr_val;
    logic [POS_W-1:0]      mid_rd_idx;
    logic [WORD_BITS-1:0]  mid_rd_word;

    // output register
    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [IDX_W-1:0]      found_reg;
    logic                  value_reg;
    logic                  full_reg;
    logic                  out_load;

    // handshake and misc
    logic                  in_accept;
    logic                  cfg_we;
    logic                  in_range;
    logic [LEAF_IDX_W-1:0] k_find;
    wu_req_t               wu_req;
    wu_rsp_t               wu_rsp;

    hbf_word_unit u_word_unit (
        .req (wu_req),
        .rsp (wu_rsp)
    );

    // handshakes, a pending register write holds off new requests
    assign in_stall  = (state_reg != ST_IDLE) || cfg_valid;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = (state_reg == ST_IDLE) ||
                       (((state_reg == ST_CLEAR) || (state_reg == ST_SWEEP)) && !reply_reg);
    assign cfg_we    = cfg_valid && cfg_ready;

    // effective size and range check
    assign used_bits = (num_bits_reg > CFG_DATA_W'(MAX_BITS)) ?
                       CFG_DATA_W'(MAX_BITS) : num_bits_reg;
    assign in_range  = ({1'b0, bit_index} < used_bits);

    // middle word read, missing words read as all ones
    assign mid_rd_idx  = (state_reg == ST_FMID) ? t_reg : idx_reg[IDX_W-1:IDX_W-POS_W];
    assign mid_rd_word = ({1'b0, mid_rd_idx} < (POS_W + 1)'(MID_COUNT)) ?
                         mid_reg[mid_rd_idx[MID_AW-1:0]] : ALL_ONES;

    assign k_find = {t_reg, wu_rsp.low_zero};

    // word unit operand select
    always_comb
    begin
        wu_req = '0;
        unique case (state_reg) inside
            ST_SWEEP:
            begin
                wu_req.word = sweep_word(LEAF_IDX_W'(sweep_cnt_reg), used_bits, invert_reg);
            end
            ST_MODIFY:
            begin
                wu_req.word = leaf_rdata_reg;
                wu_req.pos  = idx_reg[POS_W-1:0];
                wu_req.val  = (req_reg == REQ_SET) ^ invert_reg;
            end
            ST_TOP, ST_FMID:
            begin
                wu_req.word = mid_rd_word;
            end
            ST_FTOP:
            begin
                wu_req.word = top_reg;
            end
            ST_FLEAF:
            begin
                wu_req.word = k_oob_reg ? ALL_ONES : leaf_rdata_reg;
            end
            default:
            begin
                wu_req = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        idx_next        = idx_reg;
        t_next          = t_reg;
        k_next          = k_reg;
        k_oob_next      = k_oob_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        reply_next      = reply_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_value_next  = res_value_reg;
        top_next        = top_reg;
        leaf_rd_addr    = '0;
        leaf_we         = 1'b0;
        leaf_wr_addr    = '0;
        leaf_wr_data    = wu_rsp.new_word;
        mid_fill        = 1'b0;
        mid_we          = 1'b0;
        mid_wr_idx      = '0;
        mid_wr_bit      = '0;
        mid_wr_val      = 1'b0;
        out_load        = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mid_fill       = 1'b1;
                top_next       = ALL_ONES;
                sweep_cnt_next = '0;
                state_next     = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                leaf_we      = 1'b1;
                leaf_wr_addr = sweep_cnt_reg;
                leaf_wr_data = wu_req.word;
                if (!wu_rsp.all_ones)
                begin
                    mid_we     = 1'b1;
                    mid_wr_idx = POS_W'(LEAF_IDX_W'(sweep_cnt_reg) >> POS_W);
                    mid_wr_bit = POS_W'(LEAF_IDX_W'(sweep_cnt_reg));
                    mid_wr_val = 1'b0;
                    top_next[mid_wr_idx] = 1'b0;
                end
                if (sweep_cnt_reg == LEAF_AW'(LEAF_COUNT - 1))
                    state_next = reply_reg ? ST_DONE : ST_IDLE;
                else
                    sweep_cnt_next = sweep_cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                leaf_rd_addr = bit_index[LEAF_AW+POS_W-1:POS_W];
                if (in_accept)
                begin
                    req_next        = req_type;
                    idx_next        = bit_index;
                    res_status_next = STATUS_OK;
                    res_found_next  = '0;
                    res_value_next  = 1'b0;
                    case (req_type) inside
                        REQ_SET, REQ_CLEAR, REQ_TEST:
                        begin
                            if (in_range)
                                state_next = ST_MODIFY;
                            else
                            begin
                                res_status_next = STATUS_RANGE;
                                state_next      = ST_DONE;
                            end
                        end
                        REQ_FIND:
                        begin
                            if (&top_reg)
                            begin
                                res_status_next = STATUS_NOT_FOUND;
                                state_next      = ST_DONE;
                            end
                            else
                                state_next = ST_FTOP;
                        end
                        REQ_RESET_ALL:
                        begin
                            reply_next = 1'b1;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_MODIFY:
            begin
                if (req_reg == REQ_TEST)
                begin
                    res_value_next = leaf_rdata_reg[idx_reg[POS_W-1:0]] ^ invert_reg;
                    state_next     = ST_DONE;
                end
                else
                begin
                    leaf_we      = 1'b1;
                    leaf_wr_addr = idx_reg[LEAF_AW+POS_W-1:POS_W];
                    mid_we       = 1'b1;
                    mid_wr_idx   = idx_reg[IDX_W-1:IDX_W-POS_W];
                    mid_wr_bit   = idx_reg[2*POS_W-1:POS_W];
                    mid_wr_val   = wu_rsp.new_all_ones;
                    state_next   = ST_TOP;
                end
            end
            ST_TOP:
            begin
                top_next[idx_reg[IDX_W-1:IDX_W-POS_W]] = wu_rsp.all_ones;
                state_next = ST_DONE;
            end
            ST_FTOP:
            begin
                t_next     = wu_rsp.low_zero;
                state_next = ST_FMID;
            end
            ST_FMID:
            begin
                k_next       = k_find;
                k_oob_next   = ({1'b0, k_find} >= (LEAF_IDX_W + 1)'(LEAF_COUNT));
                leaf_rd_addr = k_find[LEAF_AW-1:0];
                state_next   = ST_FLEAF;
            end
            ST_FLEAF:
            begin
                res_found_next = {k_reg, wu_rsp.low_zero};
                state_next     = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    reply_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        // a register write restarts initialization
        if (cfg_we)
        begin
            reply_next = 1'b0;
            state_next = ST_CLEAR;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            reply_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            num_bits_reg  <= NUM_BITS_RESET;
            invert_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            reply_reg <= reply_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_NUM_BITS:    num_bits_reg <= cfg_data;
                    CFG_INVERT_MODE: invert_reg   <= cfg_data[0];
                    default:         num_bits_reg <= num_bits_reg;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        idx_reg        <= idx_next;
        t_reg          <= t_next;
        k_reg          <= k_next;
        k_oob_reg      <= k_oob_next;
        sweep_cnt_reg  <= sweep_cnt_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_value_reg  <= res_value_next;
        top_reg        <= top_next;
        if (out_load)
        begin
            status_reg <= res_status_reg;
            found_reg  <= res_found_reg;
            value_reg  <= res_value_reg;
            full_reg   <= &top_reg;
        end
    end

    // middle summary words
    always_ff @(posedge clk)
    begin
        if (mid_fill)
        begin
            for (int i = 0; i < MID_COUNT; i++)
                mid_reg[i] <= ALL_ONES;
        end
        else if (mid_we && ({1'b0, mid_wr_idx} < (POS_W + 1)'(MID_COUNT)))
            mid_reg[mid_wr_idx[MID_AW-1:0]][mid_wr_bit] <= mid_wr_val;
    end

    // leaf memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (leaf_we)
            leaf_mem[leaf_wr_addr] <= leaf_wr_data;
        leaf_rdata_reg <= leaf_mem[leaf_rd_addr];
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found_index = found_reg;
    assign bit_value   = value_reg;
    assign full_flag   = full_reg;

`ifndef SYNTHESIS
    // a result appears only when a request completes
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result shown without a completed request");

    // an accepted request always starts work
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !cfg_we) |=> (state_reg != ST_IDLE))
        else $error("accepted request dropped");

    // find never lands on a padding bit
    a_find_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLEAF) |-> ({1'b0, res_found_next} < used_bits))
        else $error("find returned a padding bit");

    // nothing found is reported only with a full map
    a_not_found_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == STATUS_NOT_FOUND)) |-> full_reg)
        else $error("nothing found reported on a map that is not full");
`endif

endmodule
